[src/tcw_pkg.sv]
// ---------------------------------------------------------------------------
// Text console writer package
// Screen geometry, command codes and the item types shared by the
// front end, the command queue and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // Screen geometry.
   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = COLS * ROWS;

   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CELL_W = 16;

   // Fixed field widths of the ports.
   localparam int CMD_W        = 2;
   localparam int IN_COL_W     = 7;
   localparam int IN_ROW_W     = 5;
   localparam int BYTE_W       = 8;
   localparam int CURSOR_OUT_W = 11;

   // Character codes.
   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'd15;

   // Depth of the queue between front and back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT_CHAR   = 2'd0,
      CMD_CLEAR      = 2'd1,
      CMD_SET_CURSOR = 2'd2,
      CMD_READ_CELL  = 2'd3
   } command_type;

   // One decoded command as it travels from front to back end.
   typedef struct packed {
      command_type       cmd;
      logic              use_cursor;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [ADDR_W-1:0] idx;
      logic              newline;
      logic [BYTE_W-1:0] cell_char;
      logic [BYTE_W-1:0] cell_attr;
   } op_type;

   // One result item.
   typedef struct packed {
      logic [CURSOR_OUT_W-1:0] cursor_position;
      logic [BYTE_W-1:0]       cell_char;
      logic [BYTE_W-1:0]       cell_attr;
      logic                    scrolled;
   } result_type;

   // Low bits of a cell index as reported on the result port.
   function automatic logic [CURSOR_OUT_W-1:0] cursor_out(input logic [ADDR_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return CURSOR_OUT_W'(wide);
   endfunction

endpackage

`default_nettype wire

[src/tcw_ram.sv]
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[src/tcw_front.sv]
// ---------------------------------------------------------------------------
// Text console writer front end
// Accepts commands, saturates the target cell, resolves the attribute and
// holds the decoded command in a stage register until the queue takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            init_busy,
   input  wire logic [tcw_pkg::BYTE_W-1:0]      default_attr,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [tcw_pkg::CMD_W-1:0]       req_command,
   input  wire logic                            req_use_cursor,
   input  wire logic [tcw_pkg::IN_COL_W-1:0]    req_column,
   input  wire logic [tcw_pkg::IN_ROW_W-1:0]    req_line,
   input  wire logic [tcw_pkg::BYTE_W-1:0]      req_char_code,
   input  wire logic [tcw_pkg::BYTE_W-1:0]      req_attribute,
   input  wire logic                            q_full,
   output logic                                 q_push,
   output tcw_pkg::op_type                      q_data
);
   import tcw_pkg::*;

   logic             st_valid_ff, st_valid_in;
   op_type           st_ff, st_in;
   logic             accept;
   logic [COL_W-1:0] col_sat;
   logic [ROW_W-1:0] row_sat;

   // The stage may take a new transfer unless init is busy or it holds one the queue refuses.
   assign req_full = init_busy | (st_valid_ff & q_full);
   assign accept   = req_push & ~req_full;
   assign q_push   = st_valid_ff & ~q_full;
   assign q_data   = st_ff;

   // Saturate column and row to the screen and form the cell index.
   always_comb begin
      col_sat = (32'(req_column) > COLS - 1) ? COL_W'(COLS - 1) : COL_W'(req_column);
      row_sat = (32'(req_line) > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(req_line);
      st_in            = st_ff;
      st_in.cmd        = command_type'(req_command);
      st_in.use_cursor = req_use_cursor;
      st_in.row        = row_sat;
      st_in.col        = col_sat;
      st_in.idx        = ADDR_W'(32'(row_sat) * COLS + 32'(col_sat));
      st_in.newline    = (req_char_code == NEWLINE_CODE);
      st_in.cell_char  = req_char_code;
      st_in.cell_attr  = (req_attribute == '0) ? default_attr : req_attribute;
   end

   // Stage valid flag.
   always_comb begin
      st_valid_in = st_valid_ff;
      if (accept) begin
         st_valid_in = 1'b1;
      end else if (q_push) begin
         st_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

[src/tcw_queue.sv]
// ---------------------------------------------------------------------------
// Text console writer command queue
// A short first-in first-out queue of decoded commands between the front
// end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire tcw_pkg::op_type push_data,
   output logic                 full,
   input  wire logic            pop,
   output logic                 empty,
   output tcw_pkg::op_type      head
);
   import tcw_pkg::*;

   op_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (32'(count_ff) == QUEUE_DEPTH);
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Pointer and count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/tcw_back.sv]
// ---------------------------------------------------------------------------
// Text console writer back end
// Owns the screen memory and the cursor, carries out queued commands
// (including the scroll and clear sweeps) and holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [tcw_pkg::BYTE_W-1:0]            default_attr,
   output logic                                       init_busy,
   input  wire logic                                  q_empty,
   input  wire tcw_pkg::op_type                       q_head,
   output logic                                       q_pop,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic [tcw_pkg::CURSOR_OUT_W-1:0]           rsp_cursor_position,
   output logic [tcw_pkg::BYTE_W-1:0]                 rsp_cell_char,
   output logic [tcw_pkg::BYTE_W-1:0]                 rsp_cell_attr,
   output logic                                       rsp_scrolled
);
   import tcw_pkg::*;

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_EXEC   = 7'b0000100,
      S_READ   = 7'b0001000,
      S_SCROLL = 7'b0010000,
      S_BOTTOM = 7'b0100000,
      S_CLEAR  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] ctr_ff, ctr_in;
   op_type            op_ff, op_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ADDR_W-1:0] cur_idx_ff, cur_idx_in;
   logic              res_valid_ff, res_valid_in;
   result_type        res_ff, res_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   logic [ROW_W-1:0]  tgt_row;
   logic [COL_W-1:0]  tgt_col;
   logic [ADDR_W-1:0] tgt_idx;
   logic              row_end, last_row;

   // Screen memory.
   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign init_busy           = (state_ff == S_INIT);
   assign rsp_empty           = ~res_valid_ff;
   assign rsp_cursor_position = res_ff.cursor_position;
   assign rsp_cell_char       = res_ff.cell_char;
   assign rsp_cell_attr       = res_ff.cell_attr;
   assign rsp_scrolled        = res_ff.scrolled;

   // Take a command only when the result register is free.
   assign q_pop = (state_ff == S_IDLE) & ~q_empty & ~res_valid_ff;

   // Target cell of the current command: the cursor or the given cell.
   always_comb begin
      tgt_row  = op_ff.use_cursor ? cur_row_ff : op_ff.row;
      tgt_col  = op_ff.use_cursor ? cur_col_ff : op_ff.col;
      tgt_idx  = op_ff.use_cursor ? cur_idx_ff : op_ff.idx;
      row_end  = op_ff.newline | (32'(tgt_col) == COLS - 1);
      last_row = (32'(tgt_row) == ROWS - 1);
   end

   // Command sequencer.
   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      op_in        = op_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      cur_idx_in   = cur_idx_ff;
      res_valid_in = res_valid_ff & ~rsp_pop;
      res_in       = res_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ctr_ff;
      ram_wr_data  = '0;
      ram_rd_addr  = tgt_idx;

      unique case (state_ff)
         // Zero the screen after reset.
         S_INIT: begin
            ram_wr_en = 1'b1;
            if (32'(ctr_ff) == CELLS - 1) begin
               state_in = S_IDLE;
            end else begin
               ctr_in = ctr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (q_pop) begin
               op_in    = q_head;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_in.cursor_position = cursor_out(cur_idx_ff);
            res_in.cell_char       = '0;
            res_in.cell_attr       = '0;
            res_in.scrolled        = 1'b0;
            unique case (op_ff.cmd)
               CMD_PUT_CHAR: begin
                  ram_wr_en   = ~op_ff.newline;
                  ram_wr_addr = tgt_idx;
                  ram_wr_data = {op_ff.cell_attr, op_ff.cell_char};
                  if (row_end && last_row) begin
                     // Past the last cell: scroll and land on the bottom row.
                     cur_row_in = ROW_W'(ROWS - 1);
                     cur_col_in = '0;
                     cur_idx_in = ADDR_W'(CELLS - COLS);
                     ctr_in     = '0;
                     state_in   = S_SCROLL;
                  end else begin
                     if (row_end) begin
                        cur_row_in = tgt_row + 1'b1;
                        cur_col_in = '0;
                        cur_idx_in = ADDR_W'(32'(tgt_idx) - 32'(tgt_col) + COLS);
                     end else begin
                        cur_row_in = tgt_row;
                        cur_col_in = tgt_col + 1'b1;
                        cur_idx_in = tgt_idx + 1'b1;
                     end
                     res_in.cursor_position = cursor_out(cur_idx_in);
                     res_valid_in           = 1'b1;
                     state_in               = S_IDLE;
                  end
               end
               CMD_CLEAR: begin
                  cur_row_in = '0;
                  cur_col_in = '0;
                  cur_idx_in = '0;
                  ctr_in     = '0;
                  state_in   = S_CLEAR;
               end
               CMD_SET_CURSOR: begin
                  cur_row_in             = tgt_row;
                  cur_col_in             = tgt_col;
                  cur_idx_in             = tgt_idx;
                  res_in.cursor_position = cursor_out(tgt_idx);
                  res_valid_in           = 1'b1;
                  state_in               = S_IDLE;
               end
               CMD_READ_CELL: begin
                  state_in = S_READ;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // Read data for the address given in S_EXEC comes from the registered read port.
         S_READ: begin
            res_in.cursor_position = cursor_out(cur_idx_ff);
            res_in.cell_char       = ram_rd_data[BYTE_W-1:0];
            res_in.cell_attr       = ram_rd_data[CELL_W-1:BYTE_W];
            res_in.scrolled        = 1'b0;
            res_valid_in           = 1'b1;
            state_in               = S_IDLE;
         end

         // Copy each row up by one: read a cell one row down, write it next cycle.
         S_SCROLL: begin
            ram_rd_addr = ADDR_W'(32'(ctr_ff) + COLS);
            ram_wr_en   = (ctr_ff != '0);
            ram_wr_addr = ctr_ff - 1'b1;
            ram_wr_data = ram_rd_data;
            if (32'(ctr_ff) == CELLS - COLS) begin
               state_in = S_BOTTOM;
            end else begin
               ctr_in = ctr_ff + 1'b1;
            end
         end

         // Zero the bottom row.
         S_BOTTOM: begin
            ram_wr_en = 1'b1;
            if (32'(ctr_ff) == CELLS - 1) begin
               res_in.cursor_position = cursor_out(cur_idx_ff);
               res_in.cell_char       = '0;
               res_in.cell_attr       = '0;
               res_in.scrolled        = 1'b1;
               res_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end else begin
               ctr_in = ctr_ff + 1'b1;
            end
         end

         // Fill the screen with spaces in the default attribute.
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {default_attr, SPACE_CODE};
            if (32'(ctr_ff) == CELLS - 1) begin
               res_in.cursor_position = cursor_out(cur_idx_ff);
               res_in.cell_char       = '0;
               res_in.cell_attr       = '0;
               res_in.scrolled        = 1'b0;
               res_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end else begin
               ctr_in = ctr_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ctr_ff       <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         cur_idx_ff   <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         cur_idx_ff   <= cur_idx_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      res_ff <= res_in;
   end

endmodule

`default_nettype wire

[src/text_console_writer.sv]
// ---------------------------------------------------------------------------
// Text console writer
// Character-cell console: a screen memory of character and attribute cells
// with a cursor, driven by put, clear, set-cursor and read commands.
//
// Usage:
//   Commands enter through a queue-like port: a transfer happens when
//   req_push is high and req_full is low. Each command gives exactly one
//   result, shown on the rsp_ ports while rsp_empty is low and taken by
//   rsp_pop. The default attribute is written through csr_write_enable and
//   csr_write_data; the user must write it only while the block is idle,
//   which the block itself does not enforce. A command passes a front
//   stage and a two-entry queue; the back end then carries out one command
//   at a time, limited by the single write and registered read port of the
//   screen memory. A scroll walks the whole screen and a clear writes every
//   cell. Reset: the cursor goes to zero and the default attribute to 15;
//   then a clearing pass zeroes the screen, and req_full stays high until
//   it ends. A stalled receiver holds the result register; the front stage
//   and the queue keep accepting commands until they fill up.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [tcw_pkg::BYTE_W-1:0]            csr_write_data,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire logic [tcw_pkg::CMD_W-1:0]             req_command,
   input  wire logic                                  req_use_cursor,
   input  wire logic [tcw_pkg::IN_COL_W-1:0]          req_column,
   input  wire logic [tcw_pkg::IN_ROW_W-1:0]          req_line,
   input  wire logic [tcw_pkg::BYTE_W-1:0]            req_char_code,
   input  wire logic [tcw_pkg::BYTE_W-1:0]            req_attribute,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic [tcw_pkg::CURSOR_OUT_W-1:0]           rsp_cursor_position,
   output logic [tcw_pkg::BYTE_W-1:0]                 rsp_cell_char,
   output logic [tcw_pkg::BYTE_W-1:0]                 rsp_cell_attr,
   output logic                                       rsp_scrolled
);
   import tcw_pkg::*;

   logic [BYTE_W-1:0] default_attr_ff;
   logic              init_busy;
   logic              q_push, q_full, q_pop, q_empty;
   op_type            q_in, q_head;

   // Default attribute register.
   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= RESET_ATTR;
      end else if (csr_write_enable) begin
         default_attr_ff <= csr_write_data;
      end
   end

   // Front end: accept and decode.
   tcw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .init_busy      (init_busy),
      .default_attr   (default_attr_ff),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_use_cursor (req_use_cursor),
      .req_column     (req_column),
      .req_line       (req_line),
      .req_char_code  (req_char_code),
      .req_attribute  (req_attribute),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_in)
   );

   // Command queue between the two halves.
   tcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Back end: screen memory, cursor and results.
   tcw_back u_back (
      .clock               (clock),
      .reset               (reset),
      .default_attr        (default_attr_ff),
      .init_busy           (init_busy),
      .q_empty             (q_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_char       (rsp_cell_char),
      .rsp_cell_attr       (rsp_cell_attr),
      .rsp_scrolled        (rsp_scrolled)
   );

endmodule

`default_nettype wire
